[design/bresenham_line_walker_unit_assert.svh]
// Assertion macros for the Bresenham line walker.
`ifndef BRESENHAM_LINE_WALKER_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_WALKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition holds in the same cycle as the trigger.
`define BLW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Condition holds in the cycle after the trigger.
`define BLW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`else

`define BLW_ASSERT_NOW(lbl, ante, cons)
`define BLW_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[design/blw_pkg.sv]
// Shared types and constants for the Bresenham line walker.
package blw_pkg;

	localparam int COORD_BITS = 12;
	localparam int SPAN_BITS  = COORD_BITS + 1;
	localparam int STEP_BITS  = COORD_BITS + 2;
	localparam int ERR_BITS   = COORD_BITS + 4;
	localparam int COLOR_BITS = 32;

	localparam logic [COLOR_BITS-1:0] COLOR_RESET = '1;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SPAN_BITS-1:0]         span_t;
	typedef logic [STEP_BITS-1:0]         step_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic [COLOR_BITS-1:0]        color_t;

	typedef struct packed {
		logic   operation;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} item_t;

	typedef struct packed {
		logic   swapped;
		logic   minor_up;
		coord_t major_pos;
		coord_t major_end;
		coord_t minor_pos;
		span_t  span;
		step_t  step;
	} setup_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   last;
		logic   valid;
	} pix_t;

	typedef struct packed {
		logic [1:0] count;
		logic       full;
	} qstat_t;

	typedef struct packed {
		logic active;
	} wstat_t;

endpackage

[design/blw_setup.sv]
// Line setup: steep test, axis swap, endpoint ordering, span and error step.
module blw_setup (
	input  blw_pkg::item_t  item,
	output blw_pkg::setup_t setup
);
	import blw_pkg::*;

	logic signed [SPAN_BITS-1:0] dx, dy, dm;
	span_t  adx, ady, adm;
	logic   steep, flip;
	coord_t ma0, ma1, mi0, mi1;
	coord_t p0, p1, q0, q1;

	always_comb begin
		dx  = SPAN_BITS'(item.start_x) - SPAN_BITS'(item.end_x);
		dy  = SPAN_BITS'(item.start_y) - SPAN_BITS'(item.end_y);
		adx = dx[SPAN_BITS-1] ? span_t'(-dx) : span_t'(dx);
		ady = dy[SPAN_BITS-1] ? span_t'(-dy) : span_t'(dy);
		// ties stay on x
		steep = adx < ady;

		ma0 = steep ? item.start_y : item.start_x;
		ma1 = steep ? item.end_y   : item.end_x;
		mi0 = steep ? item.start_x : item.start_y;
		mi1 = steep ? item.end_x   : item.end_y;

		flip = ma0 > ma1;
		p0 = flip ? ma1 : ma0;
		p1 = flip ? ma0 : ma1;
		q0 = flip ? mi1 : mi0;
		q1 = flip ? mi0 : mi1;

		dm  = SPAN_BITS'(q1) - SPAN_BITS'(q0);
		adm = dm[SPAN_BITS-1] ? span_t'(-dm) : span_t'(dm);

		setup.swapped   = steep;
		setup.minor_up  = q1 > q0;
		setup.major_pos = p0;
		setup.major_end = p1;
		setup.minor_pos = q0;
		setup.span      = span_t'(SPAN_BITS'(p1) - SPAN_BITS'(p0));
		setup.step      = {adm, 1'b0};
	end

endmodule

[design/blw_walker.sv]
// Walk state, pixel emission and Bresenham error update.
module blw_walker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  blw_pkg::item_t  item,
	input  blw_pkg::color_t color,
	output blw_pkg::pix_t   result,
	output blw_pkg::wstat_t status
);
	import blw_pkg::*;

	setup_t setup;

	coord_t major_pos_q, major_end_q, minor_pos_q;
	err_t   error_acc_q;
	span_t  major_span_q;
	step_t  error_step_q;
	logic   axes_swapped_q, minor_up_q, line_active_q;

	logic   start, emit, last, exceed;
	coord_t cur_major, cur_end, cur_minor, minor_next;
	span_t  cur_span;
	step_t  cur_step;
	err_t   cur_err, err_sum, span_e, err_next;
	logic   cur_swapped, cur_up;

	blw_setup u_setup (
		.item  (item),
		.setup (setup)
	);

	always_comb begin
		start       = (item.operation == OP_START);
		emit        = start || line_active_q;
		cur_major   = start ? setup.major_pos : major_pos_q;
		cur_end     = start ? setup.major_end : major_end_q;
		cur_minor   = start ? setup.minor_pos : minor_pos_q;
		cur_span    = start ? setup.span      : major_span_q;
		cur_step    = start ? setup.step      : error_step_q;
		cur_err     = start ? '0              : error_acc_q;
		cur_swapped = start ? setup.swapped   : axes_swapped_q;
		cur_up      = start ? setup.minor_up  : minor_up_q;

		last    = (cur_major == cur_end);
		err_sum = cur_err + err_t'({1'b0, cur_step});
		span_e  = err_t'({1'b0, cur_span});
		exceed  = err_sum > span_e;
		err_next   = exceed ? err_sum - (span_e + span_e) : err_sum;
		minor_next = cur_up ? cur_minor + coord_t'(1) : cur_minor - coord_t'(1);

		if (emit) begin
			result.x     = cur_swapped ? cur_minor : cur_major;
			result.y     = cur_swapped ? cur_major : cur_minor;
			result.color = color;
			result.last  = last;
			result.valid = 1'b1;
		end else begin
			result = '0;
		end

		status.active = line_active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q  <= 1'b0;
			major_pos_q    <= '0;
			major_end_q    <= '0;
			minor_pos_q    <= '0;
			error_acc_q    <= '0;
			major_span_q   <= '0;
			error_step_q   <= '0;
			axes_swapped_q <= 1'b0;
			minor_up_q     <= 1'b0;
		end else if (fire && emit) begin
			line_active_q  <= !last;
			major_pos_q    <= cur_major + coord_t'(1);
			major_end_q    <= cur_end;
			minor_pos_q    <= exceed ? minor_next : cur_minor;
			error_acc_q    <= err_next;
			major_span_q   <= cur_span;
			error_step_q   <= cur_step;
			axes_swapped_q <= cur_swapped;
			minor_up_q     <= cur_up;
		end
	end

endmodule

[design/blw_out_queue.sv]
// Two-word result queue between the walker and the output channel.
module blw_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  blw_pkg::pix_t   push_word,
	input  logic            pop,
	output logic            head_valid,
	output blw_pkg::pix_t   head_word,
	output blw_pkg::qstat_t status
);
	import blw_pkg::*;

	pix_t       slot_q [2];
	logic [1:0] count_q;
	logic       rd_ptr_q, wr_ptr_q;

	always_comb begin
		head_valid   = (count_q != 2'd0);
		head_word    = slot_q[rd_ptr_q];
		status.count = count_q;
		status.full  = (count_q == 2'd2);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/bresenham_line_walker_unit.sv]
// Top level of the Bresenham line walker: input stage, walker, result queue, color register.
//
//  channel | handshake          | word
//  --------+--------------------+---------------------------------------------------
//  in      | in_valid/in_stall  | operation, start_x, start_y, end_x, end_y
//  out     | out_valid/out_stall| pixel_x, pixel_y, pixel_color, last_pixel, pixel_valid
//  cfg     | cfg_valid/ready    | cfg_data -> draw color
//
//  One word per clock in and out when the output is not stalled.
//  The accepted word is registered in the input stage; the walker result is then
//  written into a queue slot when the stage drains, and out_valid rises once the
//  word sits in the queue; the pixel leaves when out_stall is low.
//  The walk state (position, error, span) updates as the input stage drains,
//  so back-to-back advances chain through one error add/compare per cycle.
//  in_stall is registered: it goes high when the input stage and both queue
//  slots would be full, so output stalls never reach the input combinationally.
//  Reset clears the line (no active walk), the queue and sets the color to all ones.
`include "bresenham_line_walker_unit_assert.svh"

module bresenham_line_walker_unit (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  blw_pkg::coord_t        start_x,
	input  blw_pkg::coord_t        start_y,
	input  blw_pkg::coord_t        end_x,
	input  blw_pkg::coord_t        end_y,

	output logic                   out_valid,
	input  logic                   out_stall,
	output blw_pkg::coord_t        pixel_x,
	output blw_pkg::coord_t        pixel_y,
	output blw_pkg::color_t        pixel_color,
	output logic                   last_pixel,
	output logic                   pixel_valid,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  blw_pkg::color_t        cfg_data
);
	import blw_pkg::*;

	// input stage
	item_t  item_s1;
	logic   valid_s1;
	logic   in_stall_q;
	color_t color_q;

	logic   accept, move_s1, pop, valid_next;
	logic [1:0] count_next;
	logic [1:0] total;
	logic [2:0] total_next;

	pix_t   result, head;
	wstat_t wstat;
	qstat_t qstat;

	assign cfg_ready = 1'b1;
	assign in_stall  = in_stall_q;

	always_comb begin
		accept  = in_valid && !in_stall_q;
		pop     = out_valid && !out_stall;
		// stage drains into the queue when a slot is free or one leaves now
		move_s1 = valid_s1 && (!qstat.full || pop);

		valid_next = accept || (valid_s1 && !move_s1);
		case ({move_s1, pop})
			2'b10:   count_next = qstat.count + 2'd1;
			2'b01:   count_next = qstat.count - 2'd1;
			default: count_next = qstat.count;
		endcase
		total      = qstat.count + {1'b0, valid_s1};
		total_next = {1'b0, count_next} + {2'b00, valid_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			in_stall_q <= 1'b0;
			color_q    <= COLOR_RESET;
		end else begin
			valid_s1   <= valid_next;
			in_stall_q <= (total_next == 3'd3);
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{operation: operation, start_x: start_x, start_y: start_y,
				end_x: end_x, end_y: end_y};
		end
	end

	blw_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (move_s1),
		.item   (item_s1),
		.color  (color_q),
		.result (result),
		.status (wstat)
	);

	blw_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (move_s1),
		.push_word  (result),
		.pop        (pop),
		.head_valid (out_valid),
		.head_word  (head),
		.status     (qstat)
	);

	assign pixel_x     = head.x;
	assign pixel_y     = head.y;
	assign pixel_color = head.color;
	assign last_pixel  = head.last;
	assign pixel_valid = head.valid;

	// stall flag tracks occupancy exactly
	`BLW_ASSERT_NOW(a_stall_matches_fill, 1'b1, in_stall == (total == 2'd3))
	// last pixel ends the walk
	`BLW_ASSERT_NEXT(a_last_ends_line, move_s1 && result.valid && result.last, !wstat.active)
	// an empty word carries zero fields
	`BLW_ASSERT_NOW(a_empty_word_zero, out_valid && !pixel_valid,
		pixel_x == '0 && pixel_y == '0 && pixel_color == '0 && !last_pixel)

endmodule
